/* design/tll_pkg.sv */
// Shared types, token codes, character codes and keyword table for the TINY lexer.
// Depends on nothing; every other file of the block imports it.
package tll_pkg;

    localparam int LINE_BITS    = 16;
    localparam int NUM_BITS     = 32;
    localparam int PREFIX_LEN   = 6;
    localparam int PREFIX_IDX_W = $clog2(PREFIX_LEN);
    localparam int QDEPTH       = 4;
    localparam int QPTR_W       = $clog2(QDEPTH);

    // Token kinds
    localparam logic [4:0] K_IF     = 5'd0;
    localparam logic [4:0] K_THEN   = 5'd1;
    localparam logic [4:0] K_ELSE   = 5'd2;
    localparam logic [4:0] K_END    = 5'd3;
    localparam logic [4:0] K_REPEAT = 5'd4;
    localparam logic [4:0] K_UNTIL  = 5'd5;
    localparam logic [4:0] K_READ   = 5'd6;
    localparam logic [4:0] K_WRITE  = 5'd7;
    localparam logic [4:0] K_ASSIGN = 5'd8;
    localparam logic [4:0] K_EQUAL  = 5'd9;
    localparam logic [4:0] K_LESS   = 5'd10;
    localparam logic [4:0] K_PLUS   = 5'd11;
    localparam logic [4:0] K_MINUS  = 5'd12;
    localparam logic [4:0] K_TIMES  = 5'd13;
    localparam logic [4:0] K_DIVIDE = 5'd14;
    localparam logic [4:0] K_POWER  = 5'd15;
    localparam logic [4:0] K_SEMI   = 5'd16;
    localparam logic [4:0] K_LPAREN = 5'd17;
    localparam logic [4:0] K_RPAREN = 5'd18;
    localparam logic [4:0] K_LBRACE = 5'd19;
    localparam logic [4:0] K_RBRACE = 5'd20;
    localparam logic [4:0] K_ID     = 5'd21;
    localparam logic [4:0] K_NUM    = 5'd22;
    localparam logic [4:0] K_EOF    = 5'd23;
    localparam logic [4:0] K_ERROR  = 5'd24;

    // ASCII codes
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_LF         = 8'h0a;
    localparam logic [7:0] CH_CR         = 8'h0d;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_STAR       = 8'h2a;
    localparam logic [7:0] CH_PLUS       = 8'h2b;
    localparam logic [7:0] CH_MINUS      = 8'h2d;
    localparam logic [7:0] CH_SLASH      = 8'h2f;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_COLON      = 8'h3a;
    localparam logic [7:0] CH_SEMI       = 8'h3b;
    localparam logic [7:0] CH_LESS       = 8'h3c;
    localparam logic [7:0] CH_EQUAL      = 8'h3d;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5a;
    localparam logic [7:0] CH_CARET      = 8'h5e;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7a;
    localparam logic [7:0] CH_LBRACE     = 8'h7b;
    localparam logic [7:0] CH_RBRACE     = 8'h7d;

    typedef logic [PREFIX_LEN-1:0][7:0] prefix_t;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] len;
        logic [31:0] value;
    } token_t;

    // One queue word: the tokens caused by one character, with their line.
    typedef struct packed {
        token_t      first;
        token_t      second;
        logic        pair;
        logic [15:0] line;
    } entry_t;

    // Keyword text, first character in the lowest byte; index equals the kind.
    localparam prefix_t KW_TEXT [8] = '{
        48'h0000_0000_6669,
        48'h0000_6e65_6874,
        48'h0000_6573_6c65,
        48'h0000_0064_6e65,
        48'h7461_6570_6572,
        48'h006c_6974_6e75,
        48'h0000_6461_6572,
        48'h0065_7469_7277
    };

    function automatic logic [4:0] ident_kind(prefix_t p, logic [15:0] len);
        logic [4:0] kind;
        kind = K_ID;
        if (len <= 16'(PREFIX_LEN))
        begin
            for (int i = 7; i >= 0; i--)
            begin
                if (p == KW_TEXT[i])
                begin
                    kind = 5'(i);
                end
            end
        end
        return kind;
    endfunction

endpackage

/* design/tll_front.sv */
// Scanner front end: accepts one character a cycle unless the queue is full, keeps the
// scan state and packs the tokens each character causes into one queue word. Uses tll_pkg.
module tll_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [7:0]      ch,
    input  logic            end_of_input,
    input  logic            q_full,
    output logic            push,
    output tll_pkg::entry_t push_entry
);
    import tll_pkg::*;

    typedef enum logic [4:0] {
        M_IDLE    = 5'b00001,
        M_IDENT   = 5'b00010,
        M_NUMBER  = 5'b00100,
        M_COLON   = 5'b01000,
        M_COMMENT = 5'b10000
    } mode_t;

    mode_t                mode_reg, mode_next;
    prefix_t              prefix_reg, prefix_next;
    logic [15:0]          len_reg, len_next;
    logic [NUM_BITS-1:0]  acc_reg, acc_next;
    logic [LINE_BITS-1:0] line_reg, line_next;

    logic                 in_fire;
    logic                 is_letter, is_digit, is_ws, is_nl;
    logic [NUM_BITS-1:0]  digit;
    logic [NUM_BITS+3:0]  acc_wide;
    logic [NUM_BITS-1:0]  acc_step;
    logic [15:0]          len_bump;
    logic [LINE_BITS-1:0] line_inc;
    logic [4:0]           sym_kind;
    token_t               pre_tok, idle_tok;
    logic                 pre_v, idle_v, go_idle;

    assign in_stall = q_full;
    assign in_fire  = in_valid & ~in_stall;

    assign is_letter = ((ch >= CH_LOWER_A) && (ch <= CH_LOWER_Z))
                    || ((ch >= CH_UPPER_A) && (ch <= CH_UPPER_Z));
    assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_nl     = (ch == CH_LF);
    assign is_ws     = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR);

    // acc * 10 + digit, saturate when anything spills past NUM_BITS
    assign digit    = NUM_BITS'(ch[3:0]);
    assign acc_wide = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + {4'b0, digit};
    assign acc_step = (acc_wide[NUM_BITS+3:NUM_BITS] != 4'b0) ? {NUM_BITS{1'b1}}
                                                              : acc_wide[NUM_BITS-1:0];

    assign len_bump = (len_reg != 16'hffff) ? len_reg + 16'd1 : len_reg;
    assign line_inc = (line_reg != {LINE_BITS{1'b1}}) ? line_reg + LINE_BITS'(1) : line_reg;

    always_comb
    begin
        unique case (ch)
            CH_EQUAL:  sym_kind = K_EQUAL;
            CH_LESS:   sym_kind = K_LESS;
            CH_PLUS:   sym_kind = K_PLUS;
            CH_MINUS:  sym_kind = K_MINUS;
            CH_STAR:   sym_kind = K_TIMES;
            CH_SLASH:  sym_kind = K_DIVIDE;
            CH_CARET:  sym_kind = K_POWER;
            CH_SEMI:   sym_kind = K_SEMI;
            CH_LPAREN: sym_kind = K_LPAREN;
            CH_RPAREN: sym_kind = K_RPAREN;
            default:   sym_kind = K_ERROR;
        endcase
    end

    always_comb
    begin
        mode_next   = mode_reg;
        prefix_next = prefix_reg;
        len_next    = len_reg;
        acc_next    = acc_reg;
        line_next   = line_reg;
        pre_v       = 1'b0;
        pre_tok     = '0;
        idle_v      = 1'b0;
        idle_tok    = '0;
        go_idle     = 1'b0;

        if (end_of_input)
        begin
            // flush the pending token, then end-of-file
            unique case (mode_reg)
                M_IDENT:
                begin
                    pre_v   = 1'b1;
                    pre_tok = '{ident_kind(prefix_reg, len_reg), len_reg, 32'd0};
                end
                M_NUMBER:
                begin
                    pre_v   = 1'b1;
                    pre_tok = '{K_NUM, len_reg, 32'(acc_reg)};
                end
                M_COLON:
                begin
                    pre_v   = 1'b1;
                    pre_tok = '{K_ERROR, 16'd1, 32'd0};
                end
                M_COMMENT:
                begin
                    pre_v   = 1'b1;
                    pre_tok = '{K_RBRACE, 16'd1, 32'd0};
                end
                default:
                begin
                    pre_v = 1'b0;
                end
            endcase
            idle_v      = 1'b1;
            idle_tok    = '{K_EOF, 16'd0, 32'd0};
            mode_next   = M_IDLE;
            prefix_next = '0;
            len_next    = '0;
            acc_next    = '0;
        end
        else
        begin
            unique case (mode_reg)
                M_COMMENT:
                begin
                    if (ch == CH_RBRACE)
                    begin
                        pre_v     = 1'b1;
                        pre_tok   = '{K_RBRACE, 16'd1, 32'd0};
                        mode_next = M_IDLE;
                    end
                    else if (is_nl)
                    begin
                        line_next = line_inc;
                    end
                end
                M_COLON:
                begin
                    pre_v = 1'b1;
                    if (ch == CH_EQUAL)
                    begin
                        pre_tok   = '{K_ASSIGN, 16'd2, 32'd0};
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        pre_tok = '{K_ERROR, 16'd1, 32'd0};
                        go_idle = 1'b1;
                    end
                end
                M_IDENT:
                begin
                    if (is_letter || (ch == CH_UNDERSCORE))
                    begin
                        if (len_reg < 16'(PREFIX_LEN))
                        begin
                            prefix_next[len_reg[PREFIX_IDX_W-1:0]] = ch;
                        end
                        len_next = len_bump;
                    end
                    else
                    begin
                        pre_v   = 1'b1;
                        pre_tok = '{ident_kind(prefix_reg, len_reg), len_reg, 32'd0};
                        go_idle = 1'b1;
                    end
                end
                M_NUMBER:
                begin
                    if (is_digit)
                    begin
                        acc_next = acc_step;
                        len_next = len_bump;
                    end
                    else
                    begin
                        pre_v   = 1'b1;
                        pre_tok = '{K_NUM, len_reg, 32'(acc_reg)};
                        go_idle = 1'b1;
                    end
                end
                default:
                begin
                    go_idle = 1'b1;
                end
            endcase

            if (go_idle)
            begin
                mode_next   = M_IDLE;
                prefix_next = '0;
                len_next    = '0;
                acc_next    = '0;
                if (is_nl)
                begin
                    line_next = line_inc;
                end
                else if (is_ws)
                begin
                    mode_next = M_IDLE;
                end
                else if (is_letter)
                begin
                    mode_next      = M_IDENT;
                    prefix_next[0] = ch;
                    len_next       = 16'd1;
                end
                else if (is_digit)
                begin
                    mode_next = M_NUMBER;
                    acc_next  = digit;
                    len_next  = 16'd1;
                end
                else if (ch == CH_COLON)
                begin
                    mode_next = M_COLON;
                end
                else if (ch == CH_LBRACE)
                begin
                    idle_v    = 1'b1;
                    idle_tok  = '{K_LBRACE, 16'd1, 32'd0};
                    mode_next = M_COMMENT;
                end
                else
                begin
                    idle_v   = 1'b1;
                    idle_tok = '{sym_kind, 16'd1, 32'd0};
                end
            end
        end
    end

    // both tokens of a character share the line seen before any newline count
    assign push              = in_fire & (pre_v | idle_v);
    assign push_entry.first  = pre_v ? pre_tok : idle_tok;
    assign push_entry.second = idle_tok;
    assign push_entry.pair   = pre_v & idle_v;
    assign push_entry.line   = 16'(line_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            prefix_reg <= '0;
            len_reg    <= '0;
            acc_reg    <= '0;
            line_reg   <= LINE_BITS'(1);
        end
        else if (in_fire)
        begin
            mode_reg   <= mode_next;
            prefix_reg <= prefix_next;
            len_reg    <= len_next;
            acc_reg    <= acc_next;
            line_reg   <= line_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && end_of_input) |=> (mode_reg == M_IDLE && len_reg == '0))
        else $error("scanner not idle after end of input");

    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == M_COMMENT || mode_reg == M_COLON) |-> (len_reg == '0 && acc_reg == '0))
        else $error("pending lexeme left over inside comment or colon");

endmodule

/* design/tll_queue.sv */
// Short register queue of token words between the scanner and the output side.
// Uses tll_pkg for the word type and depth.
module tll_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tll_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            avail,
    output tll_pkg::entry_t head
);
    import tll_pkg::*;

    entry_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full  = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign avail = (count_reg != '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W+1)'(QDEPTH))
        else $error("queue count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("pop from empty queue");

endmodule

/* design/tll_back.sv */
// Output side: takes token words from the queue and presents their tokens one
// at a time on the result channel. Uses tll_pkg.
module tll_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            avail,
    input  tll_pkg::entry_t head,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [4:0]      token_kind,
    output logic [15:0]     line_number,
    output logic [15:0]     token_length,
    output logic [31:0]     num_value,
    output logic            last
);
    import tll_pkg::*;

    entry_t entry_reg;
    logic   busy_reg;
    logic   sel_reg;
    logic   out_fire;
    token_t tok;

    assign tok          = sel_reg ? entry_reg.second : entry_reg.first;
    assign out_valid    = busy_reg;
    assign token_kind   = tok.kind;
    assign line_number  = entry_reg.line;
    assign token_length = tok.len;
    assign num_value    = tok.value;
    assign last         = ~entry_reg.pair | sel_reg;

    assign out_fire = busy_reg & ~out_stall;
    assign pop      = avail & (~busy_reg | (out_fire & last));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            sel_reg  <= 1'b0;
        end
        else if (pop)
        begin
            busy_reg <= 1'b1;
            sel_reg  <= 1'b0;
        end
        else if (out_fire)
        begin
            if (last)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                sel_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            entry_reg <= head;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last) |=> (out_valid && last))
        else $error("second token of a pair did not follow");

endmodule

/* design/tiny_language_lexer.sv */
// Top level of the TINY lexer: scanner front end, token queue and output side.
// Uses tll_pkg, tll_front, tll_queue and tll_back.
//
// The lexer takes one source character per word on the input channel and
// returns TINY tokens on the result channel, each with its kind, source line,
// lexeme length and (for numbers) saturated decimal value; last marks the
// final token caused by one character, which causes none, one or two tokens.
// A character is taken every cycle while the queue is not full: the scan state
// (mode, six-character keyword prefix, length, number accumulator, line count)
// is updated for each character, and the tokens it causes are written as one
// word into a four-deep queue. The output side drains that queue at one token
// per cycle while the result side does not stall, so a character causing two
// tokens is presented as two separate tokens; a token is written into the queue
// and then into the output register before it is offered on the result channel.
// The input stalls only while the queue is full. No clearing pass follows reset.
module tiny_language_lexer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  ch,
    input  logic        end_of_input,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  token_kind,
    output logic [15:0] line_number,
    output logic [15:0] token_length,
    output logic [31:0] num_value,
    output logic        last
);
    import tll_pkg::*;

    // front to queue
    logic   push;
    entry_t push_entry;
    logic   q_full;

    // queue to back
    logic   pop;
    logic   avail;
    entry_t head;

    // Classify each character and advance the scan state.
    tll_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .ch           (ch),
        .end_of_input (end_of_input),
        .q_full       (q_full),
        .push         (push),
        .push_entry   (push_entry)
    );

    // Hold token words so the two sides stall independently.
    tll_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .avail      (avail),
        .head       (head)
    );

    // Unpack each word into single tokens on the result channel.
    tll_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .avail        (avail),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_kind   (token_kind),
        .line_number  (line_number),
        .token_length (token_length),
        .num_value    (num_value),
        .last         (last)
    );

endmodule

/* sim/tll_check_pkg.sv */
// Token scoreboard for the TINY lexer bench: a scanner predictor and the store of awaited tokens.
// Depends on tll_pkg for token kinds, character codes and field widths.
`timescale 1ns / 100ps

package tll_check_pkg;
    import tll_pkg::*;

    localparam longint unsigned NUM_TOP  = (64'd1 << NUM_BITS) - 1;
    localparam longint unsigned LINE_TOP = (64'd1 << LINE_BITS) - 1;
    localparam logic [15:0]     LEN_TOP  = 16'hffff;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_WORD,
        SCAN_NUMBER,
        SCAN_COLON,
        SCAN_COMMENT
    } scan_mode_e;

    typedef struct {
        logic [4:0]  kind;
        logic [15:0] line;
        logic [15:0] len;
        logic [31:0] value;
        logic        last;
    } token_rec_t;

    // Reserved words in token-kind order
    function automatic string reserved_word(int idx);
        case (idx)
            0:       return "if";
            1:       return "then";
            2:       return "else";
            3:       return "end";
            4:       return "repeat";
            5:       return "until";
            6:       return "read";
            default: return "write";
        endcase
    endfunction

    class token_scoreboard;
        scan_mode_e      mode;
        logic [7:0]      prefix [PREFIX_LEN];
        logic [15:0]     run_len;
        longint unsigned acc;
        longint unsigned line_no;
        token_rec_t      awaited [$];
        token_rec_t      fresh [$];
        int unsigned     mismatches;

        function new();
            mismatches = 0;
            line_no    = 1;
            mode       = SCAN_IDLE;
            clear_word();
        endfunction

        function void clear_word();
            foreach (prefix[i])
            begin
                prefix[i] = 8'h00;
            end
            run_len = 16'd0;
            acc     = 0;
        endfunction

        function void add_token(logic [4:0] kind, logic [15:0] len, longint unsigned value);
            token_rec_t rec;
            rec.kind  = kind;
            rec.line  = 16'(line_no);
            rec.len   = len;
            rec.value = 32'(value);
            rec.last  = 1'b0;
            fresh.push_back(rec);
        endfunction

        function void bump_line();
            if (line_no < LINE_TOP)
            begin
                line_no++;
            end
        endfunction

        function void bump_len();
            if (run_len != LEN_TOP)
            begin
                run_len++;
            end
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        // Only a word of exactly the keyword's length can match
        function bit spells(string w);
            if (run_len != 16'(w.len()))
            begin
                return 1'b0;
            end
            for (int j = 0; j < w.len(); j++)
            begin
                if (prefix[j] != w[j])
                begin
                    return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        function void close_word();
            logic [4:0] kind;
            kind = K_ID;
            for (int i = 0; i < 8; i++)
            begin
                if (spells(reserved_word(i)))
                begin
                    kind = K_IF + 5'(i);
                    break;
                end
            end
            add_token(kind, run_len, 0);
        endfunction

        // Scan a character with nothing pending
        function void scan_idle(logic [7:0] c);
            logic [4:0] kind;
            mode = SCAN_IDLE;
            clear_word();
            if (c == CH_LF)
            begin
                bump_line();
            end
            else if (c == CH_SPACE || c == CH_TAB || c == CH_CR)
            begin
            end
            else if (is_letter(c))
            begin
                mode      = SCAN_WORD;
                prefix[0] = c;
                run_len   = 16'd1;
            end
            else if (is_digit(c))
            begin
                mode    = SCAN_NUMBER;
                acc     = c - CH_ZERO;
                run_len = 16'd1;
            end
            else if (c == CH_COLON)
            begin
                mode = SCAN_COLON;
            end
            else if (c == CH_LBRACE)
            begin
                add_token(K_LBRACE, 16'd1, 0);
                mode = SCAN_COMMENT;
            end
            else
            begin
                case (c)
                    CH_EQUAL:  kind = K_EQUAL;
                    CH_LESS:   kind = K_LESS;
                    CH_PLUS:   kind = K_PLUS;
                    CH_MINUS:  kind = K_MINUS;
                    CH_STAR:   kind = K_TIMES;
                    CH_SLASH:  kind = K_DIVIDE;
                    CH_CARET:  kind = K_POWER;
                    CH_SEMI:   kind = K_SEMI;
                    CH_LPAREN: kind = K_LPAREN;
                    CH_RPAREN: kind = K_RPAREN;
                    default:   kind = K_ERROR;
                endcase
                add_token(kind, 16'd1, 0);
            end
        endfunction

        // Note an accepted input word and queue the tokens it causes
        function void take_char(logic [7:0] c, logic eoi);
            longint unsigned d;
            fresh.delete();
            if (eoi)
            begin
                case (mode)
                    SCAN_WORD:    close_word();
                    SCAN_NUMBER:  add_token(K_NUM, run_len, acc);
                    SCAN_COLON:   add_token(K_ERROR, 16'd1, 0);
                    SCAN_COMMENT: add_token(K_RBRACE, 16'd1, 0);
                    default:      ;
                endcase
                add_token(K_EOF, 16'd0, 0);
                mode = SCAN_IDLE;
                clear_word();
            end
            else
            begin
                case (mode)
                    SCAN_COMMENT:
                    begin
                        if (c == CH_RBRACE)
                        begin
                            add_token(K_RBRACE, 16'd1, 0);
                            mode = SCAN_IDLE;
                        end
                        else if (c == CH_LF)
                        begin
                            bump_line();
                        end
                    end
                    SCAN_COLON:
                    begin
                        if (c == CH_EQUAL)
                        begin
                            add_token(K_ASSIGN, 16'd2, 0);
                            mode = SCAN_IDLE;
                        end
                        else
                        begin
                            add_token(K_ERROR, 16'd1, 0);
                            scan_idle(c);
                        end
                    end
                    SCAN_WORD:
                    begin
                        if (is_letter(c) || c == CH_UNDERSCORE)
                        begin
                            if (run_len < 16'(PREFIX_LEN))
                            begin
                                prefix[run_len] = c;
                            end
                            bump_len();
                        end
                        else
                        begin
                            close_word();
                            scan_idle(c);
                        end
                    end
                    SCAN_NUMBER:
                    begin
                        if (is_digit(c))
                        begin
                            d = c - CH_ZERO;
                            if (acc > (NUM_TOP - d) / 10)
                            begin
                                acc = NUM_TOP;
                            end
                            else
                            begin
                                acc = acc * 10 + d;
                            end
                            bump_len();
                        end
                        else
                        begin
                            add_token(K_NUM, run_len, acc);
                            scan_idle(c);
                        end
                    end
                    default: scan_idle(c);
                endcase
            end
            // mark the final token of this word
            if (fresh.size() > 0)
            begin
                fresh[fresh.size() - 1].last = 1'b1;
            end
            foreach (fresh[i])
            begin
                awaited.push_back(fresh[i]);
            end
        endfunction

        function void check_token(logic [4:0] kind, logic [15:0] line, logic [15:0] len,
                                  logic [31:0] value, logic last);
            token_rec_t want;
            if (awaited.size() == 0)
            begin
                $error("unexpected token: token_kind %0d, line_number %0d", kind, line);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            if (kind !== want.kind)
            begin
                $error("token_kind: expected %0d, got %0d", want.kind, kind);
                mismatches++;
            end
            if (line !== want.line)
            begin
                $error("line_number: expected %0d, got %0d", want.line, line);
                mismatches++;
            end
            if (len !== want.len)
            begin
                $error("token_length: expected %0d, got %0d", want.len, len);
                mismatches++;
            end
            if (value !== want.value)
            begin
                $error("num_value: expected %0d, got %0d", want.value, value);
                mismatches++;
            end
            if (last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, last);
                mismatches++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

endpackage

/* sim/tiny_language_lexer_tb.sv */
// Bench top for the TINY lexer: drives source characters, stalls the token side at random.
// Depends on tll_pkg, tll_check_pkg and the tiny_language_lexer RTL.
`timescale 1ns / 100ps

module tiny_language_lexer_tb;
    import tll_pkg::*;
    import tll_check_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  ch;
    logic        end_of_input;
    logic        out_valid;
    logic        out_stall;
    logic [4:0]  token_kind;
    logic [15:0] line_number;
    logic [15:0] token_length;
    logic [31:0] num_value;
    logic        last;

    token_scoreboard book;

    // Upper bounds of the idle draws; zero gives a stretch with no idling at all
    int unsigned gap_top   = 13;
    int unsigned stall_top = 13;
    // Words other than space, tab and carriage return sent since the random part began
    int unsigned counted;

    localparam logic [7:0] MARKS [10] = '{CH_EQUAL, CH_LESS, CH_PLUS, CH_MINUS, CH_STAR,
                                          CH_SLASH, CH_CARET, CH_SEMI, CH_LPAREN, CH_RPAREN};
    localparam logic [7:0] BLANKS [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};

    tiny_language_lexer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .ch           (ch),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_kind   (token_kind),
        .line_number  (line_number),
        .token_length (token_length),
        .num_value    (num_value),
        .last         (last)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Hard stop: far beyond the slowest legal run
    initial
    begin
        #20_000_000;
        $display("tiny_language_lexer_tb NOT OK");
        $finish;
    end

    // Check every token taken on the result side. All block outputs and out_stall
    // change only through nonblocking updates, so the values read here are the
    // ones that stood at the edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            book.check_token(token_kind, line_number, token_length, num_value, last);
        end
    end

    // Result side: draw a stall length for every token, then lower stall and
    // hold it low until a token has been taken.
    initial
    begin
        int unsigned hold;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = $urandom_range(stall_top, 0);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Offer one word after a random gap and hold it until accepted. Valid is only
    // dropped when a gap follows, so back-to-back words keep it high throughout.
    task automatic send_char(input logic [7:0] c, input logic eoi);
        int unsigned gap;
        gap = $urandom_range(gap_top, 0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        ch           <= c;
        end_of_input <= eoi;
        do @(posedge clk); while (in_stall);
        book.take_char(c, eoi);
        if (eoi || !(c == CH_SPACE || c == CH_TAB || c == CH_CR))
        begin
            counted++;
        end
    endtask

    // End mark with a random character beside it; the lexer must ignore ch here
    task automatic send_end();
        send_char(8'($urandom_range(255, 0)), 1'b1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(s[i], 1'b0);
        end
    endtask

    function automatic logic [7:0] any_letter();
        int unsigned r;
        r = $urandom_range(51, 0);
        return (r < 26) ? CH_LOWER_A + 8'(r) : CH_UPPER_A + 8'(r - 26);
    endfunction

    function automatic int unsigned pace();
        case ($urandom_range(3, 0))
            0:       return 0;
            1:       return 3;
            default: return 13;
        endcase
    endfunction

    // One random fragment of source: mostly well-formed tokens and layout,
    // with a share of noise bytes, lone colons, stray braces and end marks.
    task automatic send_piece();
        int unsigned pick;
        int          n;
        int          up;
        string       word;
        logic [7:0]  b;
        pick = $urandom_range(99, 0);
        if (pick < 14)
        begin
            // reserved word, now and then with one capital so that it scans as a name
            word = reserved_word($urandom_range(7, 0));
            up   = ($urandom_range(7, 0) == 0) ? $urandom_range(word.len() - 1, 0) : -1;
            for (int i = 0; i < word.len(); i++)
            begin
                b = word[i];
                send_char((i == up) ? b - (CH_LOWER_A - CH_UPPER_A) : b, 1'b0);
            end
        end
        else if (pick < 28)
        begin
            // identifier; mostly within the keyword prefix, sometimes longer
            n = ($urandom_range(4, 0) == 0) ? $urandom_range(14, 7) : $urandom_range(6, 1);
            send_char(any_letter(), 1'b0);
            for (int i = 1; i < n; i++)
            begin
                send_char(($urandom_range(5, 0) == 0) ? CH_UNDERSCORE : any_letter(), 1'b0);
            end
        end
        else if (pick < 42)
        begin
            // number; long runs of high digits push the value into saturation
            n = ($urandom_range(4, 0) == 0) ? $urandom_range(13, 9) : $urandom_range(5, 1);
            up = $urandom_range(1, 0);
            for (int i = 0; i < n; i++)
            begin
                b = up ? CH_NINE - 8'($urandom_range(2, 0)) : CH_ZERO + 8'($urandom_range(9, 0));
                send_char(b, 1'b0);
            end
        end
        else if (pick < 50)
        begin
            send_char(CH_COLON, 1'b0);
            send_char(CH_EQUAL, 1'b0);
        end
        else if (pick < 64)
        begin
            send_char(MARKS[$urandom_range(9, 0)], 1'b0);
        end
        else if (pick < 82)
        begin
            send_char(BLANKS[$urandom_range(3, 0)], 1'b0);
        end
        else if (pick < 88)
        begin
            // brace comment with arbitrary bytes inside; occasionally left open
            send_char(CH_LBRACE, 1'b0);
            n = $urandom_range(8, 0);
            for (int i = 0; i < n; i++)
            begin
                b = 8'($urandom_range(255, 0));
                send_char((b == CH_RBRACE) ? CH_LF : b, 1'b0);
            end
            if ($urandom_range(7, 0) != 0)
            begin
                send_char(CH_RBRACE, 1'b0);
            end
        end
        else if (pick < 93)
        begin
            send_char(8'($urandom_range(255, 0)), 1'b0);
        end
        else if (pick < 97)
        begin
            case ($urandom_range(2, 0))
                0:       send_char(CH_COLON, 1'b0);
                1:       send_char(CH_RBRACE, 1'b0);
                default: send_char(CH_UNDERSCORE, 1'b0);
            endcase
        end
        else
        begin
            send_end();
        end
    endtask

    initial
    begin
        int pieces;
        book         = new();
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        ch           <= 8'h00;
        end_of_input <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: name with underscore, digits ending a name, letter ending a
        // number, lone colon before a symbol, stray right brace, lone underscore,
        // an unlisted byte, then a comment with a newline left open at end of input.
        send_text("x_1a:;}_#{\n");
        send_end();
        // Byte extremes, a colon closed by end of input, and a second end mark in a row
        send_char(8'h00, 1'b0);
        send_char(8'hff, 1'b0);
        send_char(CH_COLON, 1'b0);
        send_end();
        send_end();

        // Random source in phases of differing pace on both sides
        counted = 0;
        pieces  = 0;
        while (counted < 600)
        begin
            if (pieces % 25 == 0)
            begin
                gap_top   = pace();
                stall_top = pace();
            end
            send_piece();
            pieces++;
        end

        // Close at full rate: a name, a number, then end of input
        gap_top   = 0;
        stall_top = 0;
        send_text("y 7");
        send_end();
        in_valid <= 1'b0;

        // Drain, then watch a little longer for anything unasked for
        while (book.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);

        if (book.mismatches == 0)
        begin
            $display("tiny_language_lexer_tb OK");
        end
        else
        begin
            $display("tiny_language_lexer_tb NOT OK");
        end
        $finish;
    end

endmodule

/* files.f */
design/tll_pkg.sv
design/tll_front.sv
design/tll_queue.sv
design/tll_back.sv
design/tiny_language_lexer.sv
sim/tll_check_pkg.sv
sim/tiny_language_lexer_tb.sv
